// ----- rtl/mexp_pkg.sv -----
// Shared constants and types for the modular exponentiation unit.
package mexp_pkg;

    // Operand precision: base, exponent and modulus use this many low bits
    localparam int OPERAND_BITS = 32;
    // Width of every field on the ports
    localparam int FIELD_BITS   = 32;
    // Effective modulus needs one more bit (zero stands for 2^OPERAND_BITS)
    localparam int MOD_BITS     = OPERAND_BITS + 1;
    // Partial sum 2r + x stays below 3m
    localparam int SUM_BITS     = OPERAND_BITS + 2;
    // Step counter of the modular multiplier
    localparam int CNT_BITS     = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;

    localparam logic [FIELD_BITS-1:0] MODULUS_RESET = FIELD_BITS'(499);

    typedef logic [OPERAND_BITS-1:0] t_operand;
    typedef logic [MOD_BITS-1:0]     t_modulus;

    // Request to the shared modular multiplier: result = x * y mod m
    typedef struct packed {
        logic     start;
        t_operand x;
        t_operand y;
        t_modulus m;
    } t_mul_req;

    // Response: done pulses for one cycle, result holds until the next start
    typedef struct packed {
        logic     done;
        t_operand result;
    } t_mul_rsp;

endpackage

// ----- rtl/mexp_in_if.sv -----
// Input channel: base and exponent word with valid/ready handshake.
interface mexp_in_if;
    logic                            valid;
    logic                            ready;
    logic [mexp_pkg::FIELD_BITS-1:0] base_value;
    logic [mexp_pkg::FIELD_BITS-1:0] exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

// ----- rtl/mexp_out_if.sv -----
// Output channel: power result word with valid/ready handshake.
interface mexp_out_if;
    logic                            valid;
    logic                            ready;
    logic [mexp_pkg::FIELD_BITS-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

// ----- rtl/mexp_modmul.sv -----
// Iterative interleaved modular multiplier: one multiplier bit per cycle.
module mexp_modmul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mexp_pkg::t_mul_req i_req,
    output mexp_pkg::t_mul_rsp o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [mexp_pkg::CNT_BITS-1:0]   r_cnt;
    mexp_pkg::t_operand              r_x;
    mexp_pkg::t_operand              r_y;
    mexp_pkg::t_operand              r_r;
    mexp_pkg::t_modulus              r_m;
    mexp_pkg::t_operand              n_r;

    logic [mexp_pkg::SUM_BITS-1:0]   w_add;
    logic [mexp_pkg::SUM_BITS-1:0]   w_mod;
    logic [mexp_pkg::SUM_BITS-1:0]   w_sum;
    logic [mexp_pkg::SUM_BITS-1:0]   w_red;
    logic [mexp_pkg::SUM_BITS-1:0]   w_red2;

    // One step: r = 2r + (y msb ? x : 0), then up to two subtractions of m
    always_comb begin
        w_add  = r_y[mexp_pkg::OPERAND_BITS-1] ? {2'b00, r_x} : '0;
        w_mod  = {1'b0, r_m};
        w_sum  = {1'b0, r_r, 1'b0} + w_add;
        w_red  = (w_sum >= w_mod) ? (w_sum - w_mod) : w_sum;
        w_red2 = (w_red >= w_mod) ? (w_red - w_mod) : w_red;
        n_r    = w_red2[mexp_pkg::OPERAND_BITS-1:0];
    end

    // Step sequencing, MSB of y first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= mexp_pkg::CNT_BITS'(mexp_pkg::OPERAND_BITS - 1);
                r_x    <= i_req.x;
                r_y    <= i_req.y;
                r_m    <= i_req.m;
                r_r    <= '0;
            end else if (r_busy) begin
                r_r   <= n_r;
                r_y   <= r_y << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_r;

endmodule

// ----- rtl/modular_exponentiation_unit.sv -----
// Top level of the modular exponentiation unit: sequencer, modulus register, output register.
//
// Each input word (base, exponent) yields one result word: base^exponent mod modulus,
// computed right to left by square and multiply; a zero exponent gives 1, and a modulus
// of zero acts as 2^32. All arithmetic runs through one shared modular multiplier
// that handles one multiplier bit per cycle. An item needs one multiplication to
// reduce the base, one per set exponent bit and one square per bit below the highest
// set bit, and a zero exponent needs none.
// The input is ready only while the sequencer is idle; a finished result waits in the
// output register without holding off the next input word. The modulus register
// (reset 499) is written through i_cfg_we / i_cfg_wdata; the user must write it only
// while the unit is idle, since the block itself does not enforce this.
module modular_exponentiation_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mexp_pkg::FIELD_BITS-1:0] i_cfg_wdata,
    mexp_in_if.sink                         i_in,
    mexp_out_if.source                      o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_MULT,
        S_SQUARE,
        S_DONE
    } t_state;

    localparam int N = mexp_pkg::OPERAND_BITS;

    t_state                          r_state;
    logic [mexp_pkg::FIELD_BITS-1:0] r_modulus;
    mexp_pkg::t_operand              r_b;
    mexp_pkg::t_operand              r_e;
    mexp_pkg::t_operand              r_acc;
    mexp_pkg::t_mul_req              r_req;
    logic                            r_out_valid;
    logic [mexp_pkg::FIELD_BITS-1:0] r_out_data;

    mexp_pkg::t_mul_rsp              w_rsp;
    mexp_pkg::t_modulus              w_mod;
    mexp_pkg::t_operand              n_e;

    // Effective modulus: zero means 2^N
    assign w_mod = (r_modulus[N-1:0] == '0) ? (mexp_pkg::MOD_BITS'(1) << N)
                                            : {1'b0, r_modulus[N-1:0]};
    assign n_e   = r_e >> 1;

    mexp_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    // Sequencer, modulus register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= mexp_pkg::MODULUS_RESET;
            r_req.start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            r_req.m     <= w_mod;

            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end

            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_e   <= i_in.exponent[N-1:0];
                        r_acc <= mexp_pkg::t_operand'(1);
                        if (i_in.exponent[N-1:0] == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            // base mod m as 1 * base mod m
                            r_req.start <= 1'b1;
                            r_req.x     <= mexp_pkg::t_operand'(1);
                            r_req.y     <= i_in.base_value[N-1:0];
                            r_state     <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE: begin
                    if (w_rsp.done) begin
                        r_b         <= w_rsp.result;
                        r_req.start <= 1'b1;
                        if (r_e[0]) begin
                            r_req.x <= w_rsp.result;
                            r_req.y <= r_acc;
                            r_state <= S_MULT;
                        end else begin
                            r_req.x <= w_rsp.result;
                            r_req.y <= w_rsp.result;
                            r_state <= S_SQUARE;
                        end
                    end
                end
                S_MULT: begin
                    if (w_rsp.done) begin
                        r_acc <= w_rsp.result;
                        if (n_e != '0) begin
                            r_req.start <= 1'b1;
                            r_req.x     <= r_b;
                            r_req.y     <= r_b;
                            r_state     <= S_SQUARE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SQUARE: begin
                    if (w_rsp.done) begin
                        r_b <= w_rsp.result;
                        r_e <= n_e;
                        if (n_e[0]) begin
                            r_req.start <= 1'b1;
                            r_req.x     <= w_rsp.result;
                            r_req.y     <= r_acc;
                            r_state     <= S_MULT;
                        end else if (n_e != '0) begin
                            r_req.start <= 1'b1;
                            r_req.x     <= w_rsp.result;
                            r_req.y     <= w_rsp.result;
                            r_state     <= S_SQUARE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // hand the word over once the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= mexp_pkg::FIELD_BITS'(r_acc);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.power_result = r_out_data;

endmodule

// ----- rtl/mexp_checker.sv -----
// Port-level assertions for the modular exponentiation unit, with bind.
module mexp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic [mexp_pkg::FIELD_BITS-1:0] i_exponent,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [mexp_pkg::FIELD_BITS-1:0] i_power_result
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_power_result)))
        else $error("result word changed or dropped while stalled");

    // One word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted word");

    // A new result appears together with the return to idle
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("result shown while the unit is still busy");

    // Zero exponent gives 1 through S_DONE and the output register when the output was free
    a_zero_exponent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid &&
         (i_exponent[mexp_pkg::OPERAND_BITS-1:0] == '0))
        |=> ##1 (i_out_valid && (i_power_result == mexp_pkg::FIELD_BITS'(1))))
        else $error("zero exponent did not give 1");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_exponent     (i_in.exponent),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_power_result (o_out.power_result)
);
